>>> rtl/coh_pkg.sv
`timescale 1ns / 1ps

package coh_pkg;

    // Gray levels per axis; the bin store holds one bin per level pair
    localparam int LEVELS    = 256;
    localparam int LEVEL_W   = 8;
    localparam int CFG_W     = 9;
    localparam int BIN_DEPTH = LEVELS * LEVELS;
    localparam int ADDR_W    = $clog2(BIN_DEPTH);
    localparam int COUNT_W   = 32;
    localparam int PROD_W    = LEVEL_W + CFG_W;

    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
    localparam logic [CFG_W-1:0]   CFG_RESET = CFG_W'(LEVELS);

    typedef enum logic [1:0] {
        OP_ACC  = 2'd0,
        OP_READ = 2'd1,
        OP_FILL = 2'd2,
        OP_NONE = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_RUN,
        ST_FILL
    } t_state;

endpackage

>>> rtl/coh_ram.sv
`timescale 1ns / 1ps

module coh_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read, old data on a same-address write
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/cooccurrence_histogram_core.sv
`timescale 1ns / 1ps

// Channel  | Direction | Handshake                  | Payload
// ---------+-----------+----------------------------+-----------------------------------------
// in       | input     | i_in_valid / o_in_ready    | i_op, i_first_level, i_second_level,
//          |           |                            | i_fill_value, i_last_pixel
// out      | output    | o_out_valid / i_out_ready  | o_bin_value, o_level_error, o_image_done
// cfg      | input     | i_cfg_valid / o_cfg_ready  | i_cfg_level_count
//
// Accumulate and read items: one per cycle while the output is not stalled; the bin
// memory is read at acceptance and written back as the item leaves the read stage into
// the output register, with the last write forwarded to a following item on the same bin.
// Fill items: the item in the read stage first enters the fill state, which writes one
// bin per cycle over all BIN_DEPTH bins; the result is then issued from the read stage.
// Reset starts the same sweep with zero, with o_in_ready low until every bin is written.
// A stalled output holds the item in the read stage and drops o_in_ready.
module cooccurrence_histogram_core (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // Item input
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic [1:0]                  i_op,
    input  logic [coh_pkg::LEVEL_W-1:0] i_first_level,
    input  logic [coh_pkg::LEVEL_W-1:0] i_second_level,
    input  logic [coh_pkg::COUNT_W-1:0] i_fill_value,
    input  logic                        i_last_pixel,
    // Result output
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic [coh_pkg::COUNT_W-1:0] o_bin_value,
    output logic                        o_level_error,
    output logic                        o_image_done,
    // Configuration
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [coh_pkg::CFG_W-1:0]   i_cfg_level_count
);

    localparam logic [coh_pkg::ADDR_W-1:0] LAST_ADDR = coh_pkg::ADDR_W'(coh_pkg::BIN_DEPTH - 1);

    coh_pkg::t_state r_state, n_state;

    logic [coh_pkg::CFG_W-1:0]   r_level_count;
    logic [coh_pkg::ADDR_W-1:0]  r_cnt, n_cnt;
    logic                        r_fill_done, n_fill_done;

    // Read stage
    logic                        r_s1_valid, n_s1_valid;
    coh_pkg::t_op                r_s1_op;
    logic [coh_pkg::ADDR_W-1:0]  r_s1_addr;
    logic                        r_s1_bad;
    logic                        r_s1_last;
    logic [coh_pkg::COUNT_W-1:0] r_s1_fill;

    // Last write, forwarded to a read that raced it
    logic                        r_fwd_valid, n_fwd_valid;
    logic [coh_pkg::ADDR_W-1:0]  r_fwd_addr;
    logic [coh_pkg::COUNT_W-1:0] r_fwd_data;

    // Output register
    logic                        r_out_valid, n_out_valid;
    logic [coh_pkg::COUNT_W-1:0] r_out_value, n_out_value;
    logic                        r_out_err, n_out_err;
    logic                        r_out_done, n_out_done;

    logic                        in_accept;
    logic                        out_free;
    logic                        s1_adv;
    logic [coh_pkg::CFG_W-1:0]   eff_levels;
    logic                        in_bad;
    logic [coh_pkg::PROD_W-1:0]  in_index;
    logic [coh_pkg::COUNT_W-1:0] rd_data;
    logic [coh_pkg::COUNT_W-1:0] cur_value;
    logic [coh_pkg::COUNT_W-1:0] inc_value;
    logic                        mem_we;
    logic [coh_pkg::ADDR_W-1:0]  mem_waddr;
    logic [coh_pkg::COUNT_W-1:0] mem_wdata;

    // Effective level count and bin index of the arriving item
    always_comb begin
        eff_levels = (r_level_count > coh_pkg::CFG_RESET) ? coh_pkg::CFG_RESET : r_level_count;
        in_bad     = ({1'b0, i_first_level} >= eff_levels) ||
                     ({1'b0, i_second_level} >= eff_levels);
        in_index   = coh_pkg::PROD_W'(i_first_level) * coh_pkg::PROD_W'(eff_levels) +
                     coh_pkg::PROD_W'(i_second_level);
    end

    assign out_free  = !r_out_valid || i_out_ready;
    assign o_in_ready = (r_state == coh_pkg::ST_RUN) && (!r_s1_valid || s1_adv);
    assign in_accept = i_in_valid && o_in_ready;

    // Take the newest value of the bin, saturating increment
    assign cur_value = (r_fwd_valid && (r_fwd_addr == r_s1_addr)) ? r_fwd_data : rd_data;
    assign inc_value = (cur_value == coh_pkg::COUNT_MAX) ? cur_value
                                                         : cur_value + coh_pkg::COUNT_W'(1);

    // Sequencer: sweeps, stage advance, write port, result
    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_fill_done = r_fill_done;
        n_fwd_valid = r_fwd_valid;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out_value = r_out_value;
        n_out_err   = r_out_err;
        n_out_done  = r_out_done;
        s1_adv      = 1'b0;
        mem_we      = 1'b0;
        mem_waddr   = r_s1_addr;
        mem_wdata   = inc_value;

        case (r_state)
            coh_pkg::ST_CLEAR, coh_pkg::ST_FILL: begin
                mem_we      = 1'b1;
                mem_waddr   = r_cnt;
                mem_wdata   = (r_state == coh_pkg::ST_CLEAR) ? '0 : r_s1_fill;
                n_fwd_valid = 1'b0;
                n_cnt       = r_cnt + coh_pkg::ADDR_W'(1);
                if (r_cnt == LAST_ADDR) begin
                    n_state     = coh_pkg::ST_RUN;
                    n_fill_done = (r_state == coh_pkg::ST_FILL);
                end
            end
            coh_pkg::ST_RUN: begin
                if (r_s1_valid) begin
                    if (r_s1_op == coh_pkg::OP_FILL && !r_fill_done) begin
                        n_state = coh_pkg::ST_FILL;
                        n_cnt   = '0;
                    end else if (out_free) begin
                        s1_adv      = 1'b1;
                        n_out_valid = 1'b1;
                        n_out_value = '0;
                        n_out_err   = 1'b0;
                        n_out_done  = 1'b0;
                        case (r_s1_op)
                            coh_pkg::OP_ACC: begin
                                n_out_done = r_s1_last;
                                n_out_err  = r_s1_bad;
                                if (!r_s1_bad) begin
                                    mem_we      = 1'b1;
                                    n_fwd_valid = 1'b1;
                                    n_out_value = inc_value;
                                end
                            end
                            coh_pkg::OP_READ: begin
                                n_out_err = r_s1_bad;
                                if (!r_s1_bad) begin
                                    n_out_value = cur_value;
                                end
                            end
                            coh_pkg::OP_FILL: begin
                                n_out_value = r_s1_fill;
                                n_fill_done = 1'b0;
                            end
                            default: begin
                                n_out_value = '0;
                            end
                        endcase
                    end
                end
            end
            default: begin
                n_state = coh_pkg::ST_CLEAR;
                n_cnt   = '0;
            end
        endcase
    end

    // Fill the read stage on acceptance, empty it when it advances
    assign n_s1_valid = in_accept || (r_s1_valid && !s1_adv);

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= coh_pkg::ST_CLEAR;
            r_cnt         <= '0;
            r_fill_done   <= 1'b0;
            r_s1_valid    <= 1'b0;
            r_fwd_valid   <= 1'b0;
            r_out_valid   <= 1'b0;
            r_level_count <= coh_pkg::CFG_RESET;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_fill_done <= n_fill_done;
            r_s1_valid  <= n_s1_valid;
            r_fwd_valid <= n_fwd_valid;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid) begin
                r_level_count <= i_cfg_level_count;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_op   <= coh_pkg::t_op'(i_op);
            r_s1_addr <= in_index[coh_pkg::ADDR_W-1:0];
            r_s1_bad  <= in_bad;
            r_s1_last <= i_last_pixel;
            r_s1_fill <= i_fill_value;
        end
        if (mem_we) begin
            r_fwd_addr <= mem_waddr;
            r_fwd_data <= mem_wdata;
        end
        r_out_value <= n_out_value;
        r_out_err   <= n_out_err;
        r_out_done  <= n_out_done;
    end

    // Bin store
    coh_ram #(
        .WIDTH (coh_pkg::COUNT_W),
        .DEPTH (coh_pkg::BIN_DEPTH)
    ) u_bins (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (in_accept),
        .i_raddr (in_index[coh_pkg::ADDR_W-1:0]),
        .o_rdata (rd_data)
    );

    assign o_out_valid   = r_out_valid;
    assign o_bin_value   = r_out_value;
    assign o_level_error = r_out_err;
    assign o_image_done  = r_out_done;
    assign o_cfg_ready   = 1'b1;

endmodule

>>> rtl/coh_checker.sv
`timescale 1ns / 1ps

module coh_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_in_valid,
    input logic                        o_in_ready,
    input logic [1:0]                  i_op,
    input logic                        o_out_valid,
    input logic                        i_out_ready,
    input logic [coh_pkg::COUNT_W-1:0] o_bin_value,
    input logic                        o_level_error
);

    // Hold a result until it is taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result dropped while stalled");

    // An out-of-range item reports an empty bin
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_level_error |-> o_bin_value == '0)
        else $error("level error with non-zero bin value");

    // A fill blocks further items while it sweeps
    a_fill_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && (i_op == coh_pkg::OP_FILL) |=> !o_in_ready)
        else $error("item taken during fill sweep");

    // Clearing pass follows reset
    a_clear_after_reset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_rst_n) |-> !o_in_ready)
        else $error("item taken before clearing pass");

endmodule

bind cooccurrence_histogram_core coh_checker u_coh_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in_valid),
    .o_in_ready    (o_in_ready),
    .i_op          (i_op),
    .o_out_valid   (o_out_valid),
    .i_out_ready   (i_out_ready),
    .o_bin_value   (o_bin_value),
    .o_level_error (o_level_error)
);
